// File: rtl/preemptive_priority_scheduler_assert.svh
// Assertion macros shared by the scheduler checker.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pps_pkg.sv
// Types and constants of the preemptive priority scheduler.
package pps_pkg;

  localparam int unsigned MAX_TASKS = 8;
  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_TASKS + 1);

  // Item kinds
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEC,
    ST_TAT,
    ST_WAIT,
    ST_RESP
  } state_e;

  // One task slot as held in the slot RAM
  typedef struct packed {
    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] burst;
    logic [7:0]           prio;
    logic [TIME_BITS-1:0] remaining;
    logic [TIME_BITS-1:0] start;
  } slot_t;

endpackage

// File: rtl/preemptive_priority_scheduler.sv
// Top level of the tick-driven preemptive priority scheduler.
//
// Each accepted beat yields exactly one result beat. Load, restart and unused kinds
// answer on the next clock. A tick scans the task slots one per cycle out of the slot
// RAM, then updates the winner and the clock in ST_DEC; a task that completes then
// passes through turnaround, waiting and response (ST_TAT, ST_WAIT, ST_RESP) on the
// shared saturating subtractor. The block accepts no new beat while a tick is in
// progress, and takes one only when the result register is free or being emptied in
// that cycle. Slot contents are undefined until loaded; only the control state, the
// pending bits and the clock are reset.
module preemptive_priority_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  slot_i,
  input  logic [15:0] arrival_i,
  input  logic [15:0] burst_i,
  input  logic [7:0]  priority_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ran_o,
  output logic [2:0]  running_slot_o,
  output logic        finished_o,
  output logic [15:0] completion_time_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] waiting_o,
  output logic [15:0] response_o,
  output logic        all_done_o,
  output logic [15:0] time_now_o
);

  import pps_pkg::*;

  state_e               state_q, state_d;
  logic [MAX_TASKS-1:0] pending_q, pending_d;
  logic [TIME_BITS-1:0] clock_q, clock_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  slot_t                best_q, best_d;
  logic [TIME_BITS-1:0] tat_q, tat_d;
  logic                 out_valid_q, out_valid_d;

  // result register (payload, no reset)
  logic        ran_q, ran_d;
  logic [2:0]  rslot_q, rslot_d;
  logic        fin_q, fin_d;
  logic [15:0] ct_q, ct_d, tatr_q, tatr_d, wt_q, wt_d, rt_q, rt_d, now_q, now_d;
  logic        alldone_q, alldone_d;

  // slot RAM
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  slot_t            ram_wdata, rd_word;
  logic [$bits(slot_t)-1:0] ram_rdata;

  // shared saturating subtractor
  logic [TIME_BITS-1:0] op_a, op_b, sub_res;
  logic [TIME_BITS:0]   sub_full;

  logic in_fire, out_fire, cand, is_first;
  logic [TIME_BITS-1:0] arr_in, bur_in, clock_inc;

  pps_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(MAX_TASKS),
    .AW   (IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_word  = slot_t'(ram_rdata);
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;
  assign arr_in   = TIME_BITS'(arrival_i);
  assign bur_in   = TIME_BITS'(burst_i);
  assign clock_inc = (clock_q != {TIME_BITS{1'b1}}) ? clock_q + 1'b1 : clock_q;

  // operand select for the subtractor
  always_comb begin
    op_a = best_q.remaining;
    op_b = TIME_BITS'(1);
    case (state_q)
      ST_TAT: begin
        op_a = clock_q;
        op_b = best_q.arrival;
      end
      ST_WAIT: begin
        op_a = tat_q;
        op_b = best_q.burst;
      end
      ST_RESP: begin
        op_a = best_q.start;
        op_b = best_q.arrival;
      end
      default: ;
    endcase
  end

  assign sub_full = {1'b0, op_a} - {1'b0, op_b};
  assign sub_res  = sub_full[TIME_BITS] ? '0 : sub_full[TIME_BITS-1:0];

  // scan compare: arrived, pending, and better than the current best
  assign cand = rd_vld_q && pending_q[rd_idx_q] && (rd_word.arrival <= clock_q) &&
                (!found_q || (rd_word.prio > best_q.prio) ||
                 ((rd_word.prio == best_q.prio) && (rd_word.arrival < best_q.arrival)));
  assign is_first = (best_q.remaining == best_q.burst);

  // state register and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pending_q   <= '0;
      clock_q     <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      clock_q     <= clock_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    tat_q      <= tat_d;
    ran_q      <= ran_d;
    rslot_q    <= rslot_d;
    fin_q      <= fin_d;
    ct_q       <= ct_d;
    tatr_q     <= tatr_d;
    wt_q       <= wt_d;
    rt_q       <= rt_d;
    now_q      <= now_d;
    alldone_q  <= alldone_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    pending_d   = pending_q;
    clock_d     = clock_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    tat_d       = tat_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;
    ran_d       = ran_q;
    rslot_d     = rslot_q;
    fin_d       = fin_q;
    ct_d        = ct_q;
    tatr_d      = tatr_q;
    wt_d        = wt_q;
    rt_d        = rt_q;
    now_d       = now_q;
    alldone_d   = alldone_q;
    ram_we      = 1'b0;
    ram_waddr   = IDX_W'(slot_i);
    ram_wdata   = '{arrival: arr_in, burst: bur_in, prio: priority_req_i,
                    remaining: bur_in, start: '0};
    ram_raddr   = cnt_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ran_d  = 1'b0;
          rslot_d = '0;
          fin_d  = 1'b0;
          ct_d   = '0;
          tatr_d = '0;
          wt_d   = '0;
          rt_d   = '0;
          case (kind_i)
            KIND_LOAD: begin
              if (32'(slot_i) < MAX_TASKS) begin
                ram_we = 1'b1;
                pending_d[IDX_W'(slot_i)] = (bur_in != '0);
              end
            end
            KIND_RESTART: begin
              pending_d = '0;
              clock_d   = '0;
            end
            default: ;
          endcase
          if (kind_i == KIND_TICK) begin
            state_d = ST_SCAN;
            cnt_d   = '0;
            found_d = 1'b0;
          end else begin
            out_valid_d = 1'b1;
            alldone_d   = (pending_d == '0);
            now_d       = 16'(clock_d);
          end
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, judge the entry read in the cycle before
        if (cnt_q != CNT_W'(MAX_TASKS)) begin
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[IDX_W-1:0];
          cnt_d    = cnt_q + 1'b1;
        end else begin
          state_d = ST_DEC;
        end
        if (cand) begin
          found_d    = 1'b1;
          best_idx_d = rd_idx_q;
          best_d     = rd_word;
        end
      end

      ST_DEC: begin
        // serve the winner and advance the clock
        clock_d = clock_inc;
        ran_d   = found_q;
        rslot_d = found_q ? 3'(best_idx_q) : '0;
        fin_d   = 1'b0;
        ct_d    = '0;
        tatr_d  = '0;
        wt_d    = '0;
        rt_d    = '0;
        now_d   = 16'(clock_inc);
        if (found_q) begin
          best_d.remaining = sub_res;
          if (is_first) begin
            best_d.start = clock_q;
          end
          ram_we    = 1'b1;
          ram_waddr = best_idx_q;
          ram_wdata = best_d;
        end
        if (found_q && (sub_res == '0)) begin
          pending_d[best_idx_q] = 1'b0;
          fin_d   = 1'b1;
          ct_d    = 16'(clock_inc);
          state_d = ST_TAT;
        end else begin
          alldone_d   = (pending_q == '0);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_TAT: begin
        tat_d   = sub_res;
        tatr_d  = 16'(sub_res);
        state_d = ST_WAIT;
      end

      ST_WAIT: begin
        wt_d    = 16'(sub_res);
        state_d = ST_RESP;
      end

      ST_RESP: begin
        rt_d        = 16'(sub_res);
        alldone_d   = (pending_q == '0);
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign ran_o             = ran_q;
  assign running_slot_o    = rslot_q;
  assign finished_o        = fin_q;
  assign completion_time_o = ct_q;
  assign turnaround_o      = tatr_q;
  assign waiting_o         = wt_q;
  assign response_o        = rt_q;
  assign all_done_o        = alldone_q;
  assign time_now_o        = now_q;

endmodule

// File: rtl/pps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pps_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`include "preemptive_priority_scheduler_assert.svh"

module pps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  kind_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        ran_o,
  input logic        finished_o,
  input logic [15:0] time_now_o
);

  import pps_pkg::*;

  // a stalled result beat stays offered
  `PPS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped")

  // a stalled result beat keeps its time stamp
  `PPS_ASSERT_NEXT(a_time_hold, out_valid_o && !out_ready_i, $stable(time_now_o), "time changed")

  // a load is answered on the next clock
  `PPS_ASSERT_NEXT(a_load_resp, in_valid_i && in_ready_o && (kind_i == KIND_LOAD), out_valid_o,
                   "load not answered")

  // a tick keeps the input side closed while it is worked on
  `PPS_ASSERT_NEXT(a_tick_busy, in_valid_i && in_ready_o && (kind_i == KIND_TICK), !in_ready_o,
                   "beat accepted during tick")

  // nothing finishes without being served
  `PPS_ASSERT_NOW(a_fin_ran, out_valid_o && finished_o, ran_o, "finish without service")

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
